// File: sv/chist_pkg.sv
// Package for the codon / nucleotide histogram block.
// Holds the state and input-mode codes, the character constants and the base-code helpers.
// No dependencies; the top level reaches it by scoped names.
`default_nettype none

package chist_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned NumBins = 64;
  localparam int unsigned BinW    = $clog2(NumBins);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [BinW-1:0] LastCodonBin = BinW'(NumBins - 1);
  localparam logic [BinW-1:0] LastNucBin   = BinW'(3);

  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7A;
  localparam logic [7:0] CaseShift = 8'h20;

  typedef enum logic [1:0] {
    MODE_CHAR = 2'd0,
    MODE_EOS  = 2'd1,
    MODE_EOI  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INC,
    ST_READ
  } state_e;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + CountW'(1);
  endfunction

  // Bit 2 set means the character is not a base.
  function automatic logic [2:0] tcag_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CharT:   r = 3'd0;
      CharC:   r = 3'd1;
      CharA:   r = 3'd2;
      CharG:   r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] acgt_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CharA:   r = 3'd0;
      CharC:   r = 3'd1;
      CharG:   r = 3'd2;
      CharT:   r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/chist_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the sequence and total bin stores.
`default_nettype none

module chist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/codon_nucleotide_histogram_top.sv
// Top level of the codon / nucleotide histogram counter.
// Depends on chist_pkg and instantiates chist_ram for the sequence and total bins.
//
//   channel   direction  signals                                    handshake
//   command   in         mode_i, symbol_i                           start_i && !busy_o
//   config    in         cfg_wdata_i                                cfg_we_i
//   result    out        bin_index_o, bin_count_o, length_count_o,  result_valid_o, one cycle
//                        is_total_o, last_bin_o
//
// For a character that lands in a bin, the bin is read from RAM in the accept cycle and
// the incremented value written back in the next. Other characters leave the block idle.
// A readout keeps busy_o high while it reads the 64 (or 4) bins; each result shows in the
// cycle after its RAM read. Reset clears per-bin valid bits at once, so no RAM
// clearing pass is needed, and an end of sequence clears the sequence bins the same way.
// The receiver cannot stall results.
`default_nettype none

module codon_nucleotide_histogram_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [7:0]                       symbol_i,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_wdata_i,
  output logic                                  result_valid_o,
  output logic      [chist_pkg::BinW-1:0]       bin_index_o,
  output logic      [chist_pkg::CountW-1:0]     bin_count_o,
  output logic      [chist_pkg::CountW-1:0]     length_count_o,
  output logic                                  is_total_o,
  output logic                                  last_bin_o
);

  localparam int unsigned BW = chist_pkg::BinW;
  localparam int unsigned CW = chist_pkg::CountW;

  chist_pkg::state_e state_q, state_d;

  logic          count_mode_q;
  logic [CW-1:0] seq_len_q, seq_len_d;
  logic [CW-1:0] tot_len_q, tot_len_d;
  logic [5:0]    part_q, part_d;
  logic          part_inv_q, part_inv_d;
  logic [1:0]    pos_q, pos_d;
  logic [chist_pkg::NumBins-1:0] seq_vld_q, seq_vld_d;
  logic [chist_pkg::NumBins-1:0] tot_vld_q, tot_vld_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [BW-1:0] rd_idx_q, rd_idx_d;
  logic [BW-1:0] last_idx_q, last_idx_d;
  logic          is_total_q, is_total_d;
  logic [CW-1:0] len_snap_q, len_snap_d;
  logic          iss_vld_q, iss_vld_d;
  logic          iss_last_q, iss_last_d;
  logic          iss_hit_q, iss_hit_d;
  logic [BW-1:0] iss_idx_q, iss_idx_d;

  logic          ram_re, ram_we;
  logic [BW-1:0] ram_raddr;
  logic [CW-1:0] seq_wdata, tot_wdata, seq_rdata, tot_rdata;

  logic [7:0]    sym_up;
  logic [2:0]    code_tcag, code_acgt;
  logic          accept;

  assign accept    = start_i && (state_q == chist_pkg::ST_IDLE);
  assign sym_up    = (symbol_i inside {[chist_pkg::LowerA:chist_pkg::LowerZ]}) ?
                     symbol_i - chist_pkg::CaseShift : symbol_i;
  assign code_tcag = chist_pkg::tcag_code(sym_up);
  assign code_acgt = chist_pkg::acgt_code(sym_up);

  always_comb begin
    logic          cod_inv;
    logic [5:0]    cod_word;
    logic [CW-1:0] seq_l;

    state_d    = state_q;
    seq_len_d  = seq_len_q;
    tot_len_d  = tot_len_q;
    part_d     = part_q;
    part_inv_d = part_inv_q;
    pos_d      = pos_q;
    seq_vld_d  = seq_vld_q;
    tot_vld_d  = tot_vld_q;
    idx_d      = idx_q;
    rd_idx_d   = rd_idx_q;
    last_idx_d = last_idx_q;
    is_total_d = is_total_q;
    len_snap_d = len_snap_q;
    iss_vld_d  = 1'b0;
    iss_last_d = iss_last_q;
    iss_hit_d  = iss_hit_q;
    iss_idx_d  = iss_idx_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = rd_idx_q;
    seq_wdata  = '0;
    tot_wdata  = '0;
    cod_inv    = part_inv_q || code_tcag[2];
    cod_word   = {part_q[3:0], code_tcag[2] ? 2'b00 : code_tcag[1:0]};
    seq_l      = seq_len_q;

    case (state_q)
      chist_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            chist_pkg::MODE_CHAR: begin
              if (!(symbol_i == chist_pkg::CharSpace || symbol_i == chist_pkg::CharNl)) begin
                if (count_mode_q) begin
                  seq_len_d = chist_pkg::sat_inc(seq_len_q);
                  tot_len_d = chist_pkg::sat_inc(tot_len_q);
                  if (!code_acgt[2]) begin
                    idx_d     = BW'(code_acgt[1:0]);
                    ram_re    = 1'b1;
                    ram_raddr = BW'(code_acgt[1:0]);
                    state_d   = chist_pkg::ST_INC;
                  end
                end else if (pos_q == 2'd2) begin
                  // Third character closes the codon; a bad codon only adds to the lengths.
                  seq_len_d  = chist_pkg::sat_inc(seq_len_q);
                  tot_len_d  = chist_pkg::sat_inc(tot_len_q);
                  part_d     = '0;
                  part_inv_d = 1'b0;
                  pos_d      = '0;
                  if (!cod_inv) begin
                    idx_d     = BW'(cod_word);
                    ram_re    = 1'b1;
                    ram_raddr = BW'(cod_word);
                    state_d   = chist_pkg::ST_INC;
                  end
                end else begin
                  part_d     = cod_word;
                  part_inv_d = cod_inv;
                  pos_d      = pos_q + 2'd1;
                end
              end
            end
            chist_pkg::MODE_EOS: begin
              // A leftover partial codon counts as one codon in the lengths.
              if (!count_mode_q && pos_q != 2'd0) begin
                seq_l     = chist_pkg::sat_inc(seq_len_q);
                tot_len_d = chist_pkg::sat_inc(tot_len_q);
              end
              len_snap_d = seq_l;
              seq_len_d  = '0;
              part_d     = '0;
              part_inv_d = 1'b0;
              pos_d      = '0;
              is_total_d = 1'b0;
              rd_idx_d   = '0;
              last_idx_d = count_mode_q ? chist_pkg::LastNucBin : chist_pkg::LastCodonBin;
              state_d    = chist_pkg::ST_READ;
            end
            chist_pkg::MODE_EOI: begin
              len_snap_d = tot_len_q;
              is_total_d = 1'b1;
              rd_idx_d   = '0;
              last_idx_d = count_mode_q ? chist_pkg::LastNucBin : chist_pkg::LastCodonBin;
              state_d    = chist_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      chist_pkg::ST_INC: begin
        ram_we           = 1'b1;
        seq_wdata        = chist_pkg::sat_inc(seq_vld_q[idx_q] ? seq_rdata : '0);
        tot_wdata        = chist_pkg::sat_inc(tot_vld_q[idx_q] ? tot_rdata : '0);
        seq_vld_d[idx_q] = 1'b1;
        tot_vld_d[idx_q] = 1'b1;
        state_d          = chist_pkg::ST_IDLE;
      end
      chist_pkg::ST_READ: begin
        ram_re     = 1'b1;
        ram_raddr  = rd_idx_q;
        iss_vld_d  = 1'b1;
        iss_idx_d  = rd_idx_q;
        iss_hit_d  = is_total_q ? tot_vld_q[rd_idx_q] : seq_vld_q[rd_idx_q];
        iss_last_d = (rd_idx_q == last_idx_q);
        if (rd_idx_q == last_idx_q) begin
          state_d = chist_pkg::ST_IDLE;
          if (!is_total_q) begin
            seq_vld_d = '0;
          end
        end else begin
          rd_idx_d = rd_idx_q + BW'(1);
        end
      end
      default: state_d = chist_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= chist_pkg::ST_IDLE;
      count_mode_q <= 1'b0;
      seq_len_q    <= '0;
      tot_len_q    <= '0;
      part_q       <= '0;
      part_inv_q   <= 1'b0;
      pos_q        <= '0;
      seq_vld_q    <= '0;
      tot_vld_q    <= '0;
      rd_idx_q     <= '0;
      last_idx_q   <= '0;
      is_total_q   <= 1'b0;
      iss_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        count_mode_q <= cfg_wdata_i;
      end
      seq_len_q  <= seq_len_d;
      tot_len_q  <= tot_len_d;
      part_q     <= part_d;
      part_inv_q <= part_inv_d;
      pos_q      <= pos_d;
      seq_vld_q  <= seq_vld_d;
      tot_vld_q  <= tot_vld_d;
      rd_idx_q   <= rd_idx_d;
      last_idx_q <= last_idx_d;
      is_total_q <= is_total_d;
      iss_vld_q  <= iss_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    len_snap_q <= len_snap_d;
    iss_last_q <= iss_last_d;
    iss_hit_q  <= iss_hit_d;
    iss_idx_q  <= iss_idx_d;
  end

  chist_ram #(
    .Width (CW),
    .Depth (chist_pkg::NumBins)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (seq_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (seq_rdata)
  );

  chist_ram #(
    .Width (CW),
    .Depth (chist_pkg::NumBins)
  ) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (tot_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (tot_rdata)
  );

  assign busy_o         = (state_q != chist_pkg::ST_IDLE);
  assign result_valid_o = iss_vld_q;
  assign bin_index_o    = iss_idx_q;
  assign bin_count_o    = !iss_hit_q ? '0 : (is_total_q ? tot_rdata : seq_rdata);
  assign length_count_o = len_snap_q;
  assign is_total_o     = is_total_q;
  assign last_bin_o     = iss_last_q;

  // A bin update never overlaps a result word on the output.
  a_inc_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chist_pkg::ST_INC) |-> !iss_vld_q)
    else $error("bin update overlaps a result word");

  // Every read cycle of a readout yields a result word in the next cycle.
  a_read_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chist_pkg::ST_READ) |=> result_valid_o)
    else $error("readout read produced no result word");

  // The last result word of a readout shows once the block is idle again.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_bin_o) |-> (state_q == chist_pkg::ST_IDLE))
    else $error("last result word while the readout is still running");

  // After a sequence readout ends, all sequence bins read as cleared.
  a_seq_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_bin_o && !is_total_o) |-> (seq_vld_q == '0))
    else $error("sequence bins not cleared after readout");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench for codon_nucleotide_histogram_top: drives sequence words and count_mode
// settings, predicts every readout with a scoreboard class and checks each result word.
// Depends on chist_pkg and the codon_nucleotide_histogram_top RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chist_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned PhaseWords   = 62;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [BinW-1:0]   index;
    logic [CountW-1:0] count;
    logic [CountW-1:0] length;
    logic              total;
    logic              last;
  } bin_word_t;

  class histogram_scoreboard;
    logic [CountW-1:0] seq_bins [NumBins];
    logic [CountW-1:0] run_bins [NumBins];
    logic [CountW-1:0] seq_length;
    logic [CountW-1:0] run_length;
    logic [5:0]        codon_bits;
    logic              codon_bad;
    int                codon_pos;
    bit                nuc_mode;
    bin_word_t         expected_bins[$];
    int                errors;

    function new();
      foreach (seq_bins[k]) begin
        seq_bins[k] = '0;
        run_bins[k] = '0;
      end
      seq_length = '0;
      run_length = '0;
      codon_bits = '0;
      codon_bad  = 1'b0;
      codon_pos  = 0;
      nuc_mode   = 1'b0;
      errors     = 0;
    endfunction

    function logic [CountW-1:0] bump(logic [CountW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void count_bin(int b);
      seq_bins[b] = bump(seq_bins[b]);
      run_bins[b] = bump(run_bins[b]);
    endfunction

    function void count_length();
      seq_length = bump(seq_length);
      run_length = bump(run_length);
    endfunction

    // A readout shows as many bins as the current setting selects.
    function void read_bins(bit total);
      bin_word_t w;
      int n;
      n = nuc_mode ? 4 : NumBins;
      for (int k = 0; k < n; k++) begin
        w.index  = BinW'(k);
        w.count  = total ? run_bins[k] : seq_bins[k];
        w.length = total ? run_length : seq_length;
        w.total  = total;
        w.last   = (k == n - 1);
        expected_bins.push_back(w);
      end
    endfunction

    function void note_word(logic [1:0] m, logic [7:0] sym);
      logic [7:0] c;
      int b;
      c = sym;
      case (m)
        MODE_CHAR: begin
          if (c == CharSpace || c == CharNl) return;
          if (c >= LowerA && c <= LowerZ) c = c - CaseShift;
          if (nuc_mode) begin
            case (c)
              CharA:   b = 0;
              CharC:   b = 1;
              CharG:   b = 2;
              CharT:   b = 3;
              default: b = -1;
            endcase
            if (b >= 0) count_bin(b);
            count_length();
          end else begin
            case (c)
              CharT:   b = 0;
              CharC:   b = 1;
              CharA:   b = 2;
              CharG:   b = 3;
              default: b = -1;
            endcase
            if (b < 0) begin
              codon_bad = 1'b1;
              b = 0;
            end
            codon_bits = {codon_bits[3:0], b[1:0]};
            codon_pos++;
            if (codon_pos == 3) begin
              if (!codon_bad) count_bin(int'(codon_bits));
              count_length();
              codon_bits = '0;
              codon_bad  = 1'b0;
              codon_pos  = 0;
            end
          end
        end
        MODE_EOS: begin
          // A leftover partial codon still counts as one codon in the lengths.
          if (!nuc_mode && codon_pos != 0) count_length();
          read_bins(1'b0);
          foreach (seq_bins[k]) seq_bins[k] = '0;
          seq_length = '0;
          codon_bits = '0;
          codon_bad  = 1'b0;
          codon_pos  = 0;
        end
        MODE_EOI: read_bins(1'b1);
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [BinW-1:0] index, logic [CountW-1:0] count,
                               logic [CountW-1:0] length, logic total, logic last);
      bin_word_t want;
      if (expected_bins.size() == 0) begin
        $display("%0t: result word with nothing expected, bin_index %0d", $time, index);
        errors++;
        return;
      end
      want = expected_bins.pop_front();
      check_field("bin_index", 64'(want.index), 64'(index));
      check_field("bin_count", 64'(want.count), 64'(count));
      check_field("length_count", 64'(want.length), 64'(length));
      check_field("is_total", 64'(want.total), 64'(total));
      check_field("last_bin", 64'(want.last), 64'(last));
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [1:0]        mode_i      = MODE_CHAR;
  logic [7:0]        symbol_i    = 8'h00;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              busy_o;
  logic              result_valid_o;
  logic [BinW-1:0]   bin_index_o;
  logic [CountW-1:0] bin_count_o;
  logic [CountW-1:0] length_count_o;
  logic              is_total_o;
  logic              last_bin_o;

  histogram_scoreboard sb;
  int                  idle_pct = 0;
  int unsigned         quiet_cycles = 0;

  codon_nucleotide_histogram_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .symbol_i       (symbol_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .bin_index_o    (bin_index_o),
    .bin_count_o    (bin_count_o),
    .length_count_o (length_count_o),
    .is_total_o     (is_total_o),
    .last_bin_o     (last_bin_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_word(mode_i, symbol_i);
      if (result_valid_o) begin
        sb.check_result(bin_index_o, bin_count_o, length_count_o, is_total_o, last_bin_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Start stays high from one word to the next unless a gap is drawn.
  task automatic put_word(logic [1:0] m, logic [7:0] sym);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    mode_i   <= m;
    symbol_i <= sym;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic put_text(string s);
    foreach (s[i]) put_word(MODE_CHAR, s[i]);
  endtask

  task automatic hold_off();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_count_mode(bit v);
    hold_off();
    // The last character word may still be in its read-modify-write.
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.nuc_mode = v;
  endtask

  // Mostly well-formed sequences with random content, the rest noise.
  task automatic random_words(int target);
    int sent;
    int len;
    int pick;
    logic [7:0] c;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 15);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(99);
          if (pick < 82) begin
            case ($urandom_range(3))
              0:       c = CharT;
              1:       c = CharC;
              2:       c = CharA;
              default: c = CharG;
            endcase
            if ($urandom_range(1)) c = c + CaseShift;
          end else if (pick < 90) begin
            c = $urandom_range(1) ? CharSpace : CharNl;
          end else begin
            c = 8'($urandom_range(255));
          end
          put_word(MODE_CHAR, c);
          sent++;
        end
        if ($urandom_range(9) != 0) begin
          put_word(MODE_EOS, 8'($urandom_range(255)));
          sent++;
        end
        if ($urandom_range(11) == 0) begin
          put_word(MODE_EOI, 8'($urandom_range(255)));
          sent++;
        end
        if ($urandom_range(9) == 0) hold_off();
      end else begin
        case ($urandom_range(3))
          0: begin
            c = 8'($urandom_range(255));
            put_word(MODE_CHAR, c);
          end
          1: put_word(MODE_NONE, 8'($urandom_range(255)));
          2: put_word(MODE_EOS, 8'($urandom_range(255)));
          default: put_word(MODE_EOI, 8'($urandom_range(255)));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    int pct_tab [NumPhases];
    bit mode_tab [NumPhases];
    pct_tab  = '{0, 77, 0, 31, 77, 31};
    mode_tab = '{0, 1, 0, 1, 0, 1};
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Codon mode: mixed case, dropped whitespace, an invalid codon, odd bytes,
    // then a partial codon closed by end of sequence.
    put_text("TCAggg \nANG");
    put_word(MODE_CHAR, 8'h00);
    put_word(MODE_CHAR, 8'hFF);
    put_text(">C");
    put_word(MODE_EOS, 8'h00);
    // One base left pending across the switch to nucleotide counting.
    put_text("T");
    put_word(MODE_NONE, 8'hFF);
    put_word(MODE_EOI, 8'h00);
    write_count_mode(1'b1);
    put_text("acGtX");
    put_word(MODE_EOS, 8'hFF);

    for (int p = 0; p < NumPhases; p++) begin
      write_count_mode(mode_tab[p]);
      idle_pct = pct_tab[p];
      random_words(PhaseWords);
    end

    hold_off();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
